FILE: hw/rtl/cmyka_alpha_over_compositor_assert.svh
// assertion macros shared by the compositor rtl
`ifndef CMYKA_ALPHA_OVER_COMPOSITOR_ASSERT_SVH
`define CMYKA_ALPHA_OVER_COMPOSITOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CAO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold, sampled on clk, off while rst_n is low
`define CAO_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/cao_pkg.sv
// types, constants and rounding helper of the cmyk plus alpha compositor
package cao_pkg;

    localparam int PIX_W = 8;
    localparam int NUM_INKS = 4;
    localparam logic [PIX_W-1:0] FULL = 8'd255;

    // composite mode codes
    localparam logic [1:0] MODE_OVER  = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY = 1'b1;

    // what the back end has to do with a transaction
    typedef enum logic [1:0] {
        CLS_DST,
        CLS_SRC,
        CLS_ZERO,
        CLS_BLEND
    } cls_t;

    typedef struct packed {
        logic [PIX_W-1:0] src_cyan;
        logic [PIX_W-1:0] src_magenta;
        logic [PIX_W-1:0] src_yellow;
        logic [PIX_W-1:0] src_black;
        logic [PIX_W-1:0] src_alpha;
        logic [PIX_W-1:0] dst_cyan;
        logic [PIX_W-1:0] dst_magenta;
        logic [PIX_W-1:0] dst_yellow;
        logic [PIX_W-1:0] dst_black;
        logic [PIX_W-1:0] dst_alpha;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_cyan;
        logic [PIX_W-1:0] out_magenta;
        logic [PIX_W-1:0] out_yellow;
        logic [PIX_W-1:0] out_black;
        logic [PIX_W-1:0] out_alpha;
    } out_item_t;

    typedef struct packed {
        logic [NUM_INKS-1:0][PIX_W-1:0] ink;   // cyan, magenta, yellow, black
        logic [PIX_W-1:0]               alpha;
    } pix_t;

    // queue entry between front and back
    typedef struct packed {
        cls_t             cls;
        pix_t             src;
        pix_t             dst;
        logic [PIX_W-1:0] a;      // source alpha after opacity
    } q_item_t;

    // one back end pipeline stage
    typedef struct packed {
        cls_t                              cls;
        pix_t                              src;
        pix_t                              dst;
        logic [PIX_W-1:0]                  a;
        logic [2*PIX_W-1:0]                prod;
        logic [PIX_W-1:0]                  n;
        logic [2*PIX_W-1:0]                num;
        logic                              ovf;
        logic [PIX_W-1:0]                  rem;
        logic [PIX_W-1:0]                  quo;
        logic                              copy;
        logic [NUM_INKS-1:0]               neg;
        logic [NUM_INKS-1:0][2*PIX_W-1:0]  iprod;
    } bk_stage_t;

    // round(p / 255) for p up to 255 * 255
    function automatic logic [PIX_W-1:0] div255_rnd(input logic [2*PIX_W-1:0] p);
        logic [2*PIX_W-1:0] x;
        logic [2*PIX_W:0]   s;
        x = p + 16'd127;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

FILE: hw/rtl/cao_front.sv
// front end: configuration registers, input register and classification
module cao_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cao_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cao_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  cao_pkg::in_item_t               in_data,
    output logic                            q_push,
    output cao_pkg::q_item_t                q_item,
    input  logic                            q_full
);

    logic [1:0]                  mode_reg;
    logic [cao_pkg::PIX_W-1:0]   opacity_reg;
    logic                        fr_v_reg;
    logic                        fr_v_next;
    cao_pkg::in_item_t           fr_item_reg;
    logic [2*cao_pkg::PIX_W-1:0] fr_prod_reg;
    logic                        in_accept;
    logic [cao_pkg::PIX_W-1:0]   scaled_a;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= cao_pkg::MODE_OVER;
            opacity_reg <= cao_pkg::FULL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cao_pkg::REG_MODE:    mode_reg    <= cfg_wdata[1:0];
                cao_pkg::REG_OPACITY: opacity_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // input handshake
    assign q_push    = fr_v_reg && !q_full;
    assign in_stall  = fr_v_reg && q_full;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        fr_v_next = fr_v_reg;
        if (in_accept)
            fr_v_next = 1'b1;
        else if (q_push)
            fr_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_v_reg <= 1'b0;
        else
            fr_v_reg <= fr_v_next;
    end

    // input register with source alpha times opacity
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fr_item_reg <= in_data;
            fr_prod_reg <= {8'd0, in_data.src_alpha} * {8'd0, opacity_reg};
        end
    end

    assign scaled_a = cao_pkg::div255_rnd(fr_prod_reg);

    // classification of the registered transaction
    always_comb
    begin
        q_item.src.ink   = {fr_item_reg.src_cyan, fr_item_reg.src_magenta,
                            fr_item_reg.src_yellow, fr_item_reg.src_black};
        q_item.src.alpha = fr_item_reg.src_alpha;
        q_item.dst.ink   = {fr_item_reg.dst_cyan, fr_item_reg.dst_magenta,
                            fr_item_reg.dst_yellow, fr_item_reg.dst_black};
        q_item.dst.alpha = fr_item_reg.dst_alpha;
        q_item.a         = scaled_a;
        case (mode_reg)
            cao_pkg::MODE_COPY:  q_item.cls = cao_pkg::CLS_SRC;
            cao_pkg::MODE_CLEAR: q_item.cls = cao_pkg::CLS_ZERO;
            default:
            begin
                if (fr_item_reg.src_alpha == '0)
                    q_item.cls = cao_pkg::CLS_DST;
                else if (scaled_a == cao_pkg::FULL)
                    q_item.cls = cao_pkg::CLS_SRC;
                else
                    q_item.cls = cao_pkg::CLS_BLEND;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cao_queue.sv
// short fifo between the front and back ends
module cao_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cao_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output cao_pkg::q_item_t head_item,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    cao_pkg::q_item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_next;

    assign full      = (cnt_reg == DEPTH_CNT);
    assign empty     = (cnt_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    `include "cmyka_alpha_over_compositor_assert.svh"

    `CAO_ASSERT_IMP(a_pop_not_empty, pop, cnt_reg != '0, "queue popped while empty")
    `CAO_ASSERT_IMP(a_push_not_full, push, cnt_reg != DEPTH_CNT, "queue pushed while full")
    `CAO_ASSERT_NEVER(a_cnt_range, cnt_reg > DEPTH_CNT, "queue count beyond depth")

endmodule

FILE: hw/rtl/cao_back.sv
// back end: new alpha, pipelined blend-factor divider, ink blend, output register
module cao_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cao_pkg::q_item_t  q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output cao_pkg::out_item_t out_data
);

    // step 0 product, 1 new alpha, 2 numerator, 3 overflow check,
    // 4..11 one quotient bit each, 12 blend factor and ink products
    localparam int NSTG     = 13;
    localparam int DIV_TOP  = 11;   // stage that resolves quotient bit 0
    localparam int DIV_LOW  = 4;
    localparam int LAST     = NSTG - 1;

    cao_pkg::bk_stage_t  stg_reg  [NSTG];
    cao_pkg::bk_stage_t  stg_next [NSTG];
    logic [NSTG-1:0]     stg_v_reg;
    logic [NSTG-1:0]     stg_v_next;
    cao_pkg::out_item_t  out_reg;
    cao_pkg::out_item_t  out_next;
    logic                out_v_reg;
    logic                adv;

    // the whole pipeline moves unless a finished transaction is held
    assign adv       = !out_v_reg || !out_stall;
    assign q_pop     = adv && !q_empty;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        stg_v_next = {stg_v_reg[NSTG-2:0], q_pop};
    end

    // per-stage datapath
    always_comb
    begin
        logic [cao_pkg::PIX_W:0]   rem2;
        logic [cao_pkg::PIX_W-1:0] t;
        logic [cao_pkg::PIX_W-1:0] diff;

        // step 0: (255 - dst alpha) * a
        stg_next[0]      = stg_reg[0];
        stg_next[0].cls  = q_item.cls;
        stg_next[0].src  = q_item.src;
        stg_next[0].dst  = q_item.dst;
        stg_next[0].a    = q_item.a;
        stg_next[0].prod = {8'd0, cao_pkg::FULL - q_item.dst.alpha} * {8'd0, q_item.a};

        // step 1: new alpha
        stg_next[1]   = stg_reg[0];
        stg_next[1].n = stg_reg[0].dst.alpha + cao_pkg::div255_rnd(stg_reg[0].prod);

        // step 2: rounded numerator a * 255 + n / 2
        stg_next[2]     = stg_reg[1];
        stg_next[2].num = {stg_reg[1].a, 8'd0} - {8'd0, stg_reg[1].a}
                        + {9'd0, stg_reg[1].n[7:1]};

        // step 3: saturation test and divider start
        stg_next[3]     = stg_reg[2];
        stg_next[3].ovf = stg_reg[2].num >= {stg_reg[2].n, 8'd0};
        stg_next[3].rem = stg_reg[2].num[15:8];
        stg_next[3].quo = '0;

        // steps 4..11: restoring division, one quotient bit per stage
        for (int k = DIV_LOW; k <= DIV_TOP; k++)
        begin
            stg_next[k] = stg_reg[k-1];
            rem2 = {stg_reg[k-1].rem, stg_reg[k-1].num[DIV_TOP - k]};
            if (rem2 >= {1'b0, stg_reg[k-1].n})
            begin
                stg_next[k].rem = 8'(rem2 - {1'b0, stg_reg[k-1].n});
                stg_next[k].quo[DIV_TOP - k] = 1'b1;
            end
            else
            begin
                stg_next[k].rem = rem2[7:0];
            end
        end

        // step 12: blend factor and ink difference products
        stg_next[LAST] = stg_reg[DIV_TOP];
        if (stg_reg[DIV_TOP].n == '0)
            t = stg_reg[DIV_TOP].a;
        else if (stg_reg[DIV_TOP].ovf)
            t = cao_pkg::FULL;
        else
            t = stg_reg[DIV_TOP].quo;
        stg_next[LAST].copy = (stg_reg[DIV_TOP].cls == cao_pkg::CLS_SRC)
                           || (stg_reg[DIV_TOP].cls == cao_pkg::CLS_BLEND
                               && t == cao_pkg::FULL);
        for (int j = 0; j < cao_pkg::NUM_INKS; j++)
        begin
            stg_next[LAST].neg[j] = stg_reg[DIV_TOP].src.ink[j]
                                  < stg_reg[DIV_TOP].dst.ink[j];
            diff = stg_next[LAST].neg[j]
                 ? stg_reg[DIV_TOP].dst.ink[j] - stg_reg[DIV_TOP].src.ink[j]
                 : stg_reg[DIV_TOP].src.ink[j] - stg_reg[DIV_TOP].dst.ink[j];
            stg_next[LAST].iprod[j] = {8'd0, diff} * {8'd0, t};
        end
    end

    // output selection
    always_comb
    begin
        cao_pkg::pix_t res;
        res = stg_reg[LAST].dst;
        if (stg_reg[LAST].copy)
            res = stg_reg[LAST].src;
        else
        begin
            case (stg_reg[LAST].cls)
                cao_pkg::CLS_ZERO: res = '0;
                cao_pkg::CLS_BLEND:
                begin
                    for (int j = 0; j < cao_pkg::NUM_INKS; j++)
                    begin
                        if (stg_reg[LAST].neg[j])
                            res.ink[j] = stg_reg[LAST].dst.ink[j]
                                       - cao_pkg::div255_rnd(stg_reg[LAST].iprod[j]);
                        else
                            res.ink[j] = stg_reg[LAST].dst.ink[j]
                                       + cao_pkg::div255_rnd(stg_reg[LAST].iprod[j]);
                    end
                    res.alpha = stg_reg[LAST].n;
                end
                default: res = stg_reg[LAST].dst;
            endcase
        end
        out_next.out_cyan    = res.ink[3];
        out_next.out_magenta = res.ink[2];
        out_next.out_yellow  = res.ink[1];
        out_next.out_black   = res.ink[0];
        out_next.out_alpha   = res.alpha;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_v_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            stg_v_reg <= stg_v_next;
            out_v_reg <= stg_v_reg[LAST];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
                stg_reg[k] <= stg_next[k];
            out_reg <= out_next;
        end
    end

    `include "cmyka_alpha_over_compositor_assert.svh"

    `CAO_ASSERT_IMP(a_alpha_grows, stg_v_reg[1] && stg_reg[1].cls == cao_pkg::CLS_BLEND, stg_reg[1].n >= stg_reg[1].a, "new alpha below scaled source alpha")
    `CAO_ASSERT_IMP(a_quo_low, stg_v_reg[DIV_TOP] && stg_reg[DIV_TOP].n != '0 && !stg_reg[DIV_TOP].ovf, ({9'd0, stg_reg[DIV_TOP].quo} * {9'd0, stg_reg[DIV_TOP].n}) <= {1'b0, stg_reg[DIV_TOP].num}, "divider quotient too large")
    `CAO_ASSERT_IMP(a_quo_high, stg_v_reg[DIV_TOP] && stg_reg[DIV_TOP].n != '0 && !stg_reg[DIV_TOP].ovf, {1'b0, stg_reg[DIV_TOP].num} < ({9'd0, stg_reg[DIV_TOP].quo} * {9'd0, stg_reg[DIV_TOP].n} + {9'd0, stg_reg[DIV_TOP].n}), "divider quotient too small")

endmodule

FILE: hw/rtl/cmyka_alpha_over_compositor.sv
// Composites one CMYK plus alpha source pixel onto a destination pixel per transaction.
// Sustained rate is one pixel per clock while the output is not stalled. An accepted
// transaction passes through the input register, which is loaded with the opacity
// multiply, then through the queue and then through a 14-stage back end (13 pipeline
// stages and the output register) whose depth is set by the eight-stage restoring
// divider that forms the blend factor. The queue of QUEUE_DEPTH entries lets input
// acceptance continue while the output is stalled.
// Configuration writes are taken at any time but must only be issued while idle.
module cmyka_alpha_over_compositor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cao_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cao_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  cao_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output cao_pkg::out_item_t              out_data
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    cao_pkg::q_item_t q_push_item;
    cao_pkg::q_item_t q_head_item;

    // accept and classify
    cao_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_push    (q_push),
        .q_item    (q_push_item),
        .q_full    (q_full)
    );

    // decoupling queue
    cao_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .empty     (q_empty)
    );

    // blend pipeline
    cao_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_head_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
